// ===== rtl/core/vwmcf_pkg.sv =====
// ---------------------------------------------------------------------------
// vwmcf_pkg
// Shared types and constants of the view weighted map cell fusion pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package vwmcf_pkg;

   // grid and fixed point constants
   localparam int                GRID_DIM    = 1024;
   localparam logic [16:0]       ONE_Q16     = 17'd65536;
   localparam logic signed [18:0] PI_Q12     = 19'sd12868;
   localparam logic signed [18:0] TWO_PI_Q12 = 19'sd25736;
   localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
   localparam logic [39:0]       EXP_CUTOFF  = 40'd786432;

   // reciprocals for divide by 6 (shift 23) and by 3 (shift 16)
   localparam logic [20:0]       RECIP6      = 21'd1398102;
   localparam logic [14:0]       RECIP3      = 15'd21846;

   // number of pipeline slots
   localparam int                NUM_STAGES  = 36;

   // register indexes
   localparam logic [2:0] REG_ROBOT_COL     = 3'd0;
   localparam logic [2:0] REG_ROBOT_ROW     = 3'd1;
   localparam logic [2:0] REG_HEADING       = 3'd2;
   localparam logic [2:0] REG_HALF_FOV      = 3'd3;
   localparam logic [2:0] REG_ANGLE_SCALE   = 3'd4;
   localparam logic [2:0] REG_DIST_SCALE    = 3'd5;
   localparam logic [2:0] REG_DEPOSIT_SCALE = 3'd6;
   localparam logic [2:0] REG_DECAY         = 3'd7;

   // register reset values
   localparam logic [13:0] RST_HALF_FOV      = 14'd2144;
   localparam logic [15:0] RST_ANGLE_SCALE   = 16'd983;
   localparam logic [23:0] RST_DIST_SCALE    = 24'd1864;
   localparam logic [16:0] RST_DEPOSIT_SCALE = 17'd19661;
   localparam logic [16:0] RST_DECAY         = 17'd64881;

   // arctangent of 2^-i in Q.16 radians
   localparam logic [19:0] ATAN_TAB [16] = '{
      20'd51472, 20'd30385, 20'd16055, 20'd8150, 20'd4091, 20'd2047, 20'd1024, 20'd512,
      20'd256,   20'd128,   20'd64,    20'd32,   20'd16,   20'd8,    20'd4,    20'd2
   };

   // one cell word as it travels down the pipeline
   typedef struct packed {
      logic                vis;
      logic                org;
      logic [31:0]         val;
      logic [16:0]         conf;
      logic [18:0]         ax;
      logic [18:0]         ay;
      logic signed [22:0]  cx;
      logic signed [22:0]  cy;
      logic signed [19:0]  cz;
      logic                fov;
      logic [13:0]         mag;
      logic [37:0]         axx;
      logic [37:0]         ayy;
      logic [38:0]         sq;
      logic [29:0]         t;
      logic [59:0]         t2;
      logic [43:0]         p0;
      logic [42:0]         p1;
      logic [35:0]         a_ang;
      logic [38:0]         a_dist;
      logic                zero;
      logic                big;
      logic [27:0]         ex;
      logic [23:0]         ex2;
      logic [19:0]         ex3;
      logic [15:0]         ex4;
      logic [16:0]         d6;
      logic [11:0]         d24;
      logic [32:0]         p;
      logic [16:0]         w;
   } lane_type;

endpackage

`default_nettype wire

// ===== rtl/core/view_weighted_map_cell_fusion.sv =====
// ---------------------------------------------------------------------------
// view_weighted_map_cell_fusion
// Fuses one map cell word per cycle, unless stalled, with a view dependent weight.
// ---------------------------------------------------------------------------
// The block takes one cell word per clock while req_stall is low and returns one
// result word per cell, in order. The word passes through 36 pipeline slots: an
// input slot for decay, offsets and quadrant fold, a chain of 16 bearing rotation
// cells, nine slots of angle, distance and polynomial arithmetic, a chain of 8
// squaring cells, a weight slot and the output register. Every slot passes on
// its word independently, so a stall on the result side only holds the input
// once all slots are full. The user must write registers through the csr port
// only while no cell is in flight; the block itself does not enforce this.
`default_nettype none

module view_weighted_map_cell_fusion (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration write port
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_wdata,
   // cell words in
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [9:0]  req_cell_col,
   input  wire logic [9:0]  req_cell_row,
   input  wire logic        req_in_view,
   input  wire logic        req_apply_decay,
   input  wire logic [31:0] req_prev_value,
   input  wire logic [16:0] req_prev_conf,
   // result words out
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_new_value,
   output logic [16:0]      rsp_new_conf,
   output logic [16:0]      rsp_view_weight
);

   localparam int ST_IN     = 0;
   localparam int ST_ROT0   = 1;
   localparam int ST_ANG    = 17;
   localparam int ST_MUL1   = 18;
   localparam int ST_MUL2   = 19;
   localparam int ST_SUM    = 20;
   localparam int ST_EXP0   = 21;
   localparam int ST_EXP2   = 22;
   localparam int ST_EXP3   = 23;
   localparam int ST_EXP4   = 24;
   localparam int ST_POLY   = 25;
   localparam int ST_SQR0   = 26;
   localparam int ST_WGT    = 34;
   localparam int ST_OUT    = 35;

   // configuration registers
   logic signed [18:0] robot_col_ff;
   logic signed [18:0] robot_row_ff;
   logic signed [15:0] heading_ff;
   logic [13:0]        half_fov_ff;
   logic [15:0]        angle_scale_ff;
   logic [23:0]        dist_scale_ff;
   logic [16:0]        deposit_scale_ff;
   logic [16:0]        decay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         robot_col_ff     <= '0;
         robot_row_ff     <= '0;
         heading_ff       <= '0;
         half_fov_ff      <= vwmcf_pkg::RST_HALF_FOV;
         angle_scale_ff   <= vwmcf_pkg::RST_ANGLE_SCALE;
         dist_scale_ff    <= vwmcf_pkg::RST_DIST_SCALE;
         deposit_scale_ff <= vwmcf_pkg::RST_DEPOSIT_SCALE;
         decay_ff         <= vwmcf_pkg::RST_DECAY;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            vwmcf_pkg::REG_ROBOT_COL:     robot_col_ff     <= $signed(csr_wdata[18:0]);
            vwmcf_pkg::REG_ROBOT_ROW:     robot_row_ff     <= $signed(csr_wdata[18:0]);
            vwmcf_pkg::REG_HEADING:       heading_ff       <= $signed(csr_wdata[15:0]);
            vwmcf_pkg::REG_HALF_FOV:      half_fov_ff      <= csr_wdata[13:0];
            vwmcf_pkg::REG_ANGLE_SCALE:   angle_scale_ff   <= csr_wdata[15:0];
            vwmcf_pkg::REG_DIST_SCALE:    dist_scale_ff    <= csr_wdata[23:0];
            vwmcf_pkg::REG_DEPOSIT_SCALE: deposit_scale_ff <= csr_wdata[16:0];
            vwmcf_pkg::REG_DECAY:         decay_ff         <= csr_wdata[16:0];
         endcase
      end
   end

   // factors above one act as one
   logic [16:0] dec;
   logic [16:0] dep;

   assign dec = (decay_ff > vwmcf_pkg::ONE_Q16) ? vwmcf_pkg::ONE_Q16 : decay_ff;
   assign dep = (deposit_scale_ff > vwmcf_pkg::ONE_Q16) ? vwmcf_pkg::ONE_Q16
                                                        : deposit_scale_ff;

   // pipeline slots
   vwmcf_pkg::lane_type stg_d  [vwmcf_pkg::NUM_STAGES];
   logic                stg_v  [vwmcf_pkg::NUM_STAGES];
   logic                stg_en [vwmcf_pkg::NUM_STAGES+1];

   assign stg_en[vwmcf_pkg::NUM_STAGES] = !rsp_stall;
   assign req_stall = !stg_en[ST_IN];

   // input slot: decay, offsets from the robot, quadrant fold
   vwmcf_pkg::lane_type nx_in;
   logic [16:0]         conf_c;
   logic [48:0]         vprod;
   logic [33:0]         cprod;
   logic signed [19:0]  dx;
   logic signed [19:0]  dy;
   logic signed [22:0]  xe;
   logic signed [22:0]  ye;

   always_comb begin
      nx_in  = '0;
      conf_c = (req_prev_conf > vwmcf_pkg::ONE_Q16) ? vwmcf_pkg::ONE_Q16 : req_prev_conf;
      vprod  = 49'(req_prev_value) * 49'(dec) + 49'd32768;
      cprod  = 34'(conf_c) * 34'(dec) + 34'd32768;
      if (req_apply_decay) begin
         nx_in.val  = vprod[47:16];
         nx_in.conf = cprod[32:16];
      end else begin
         nx_in.val  = req_prev_value;
         nx_in.conf = conf_c;
      end
      nx_in.vis = req_in_view
                  && ({1'b0, req_cell_col} < 11'(vwmcf_pkg::GRID_DIM))
                  && ({1'b0, req_cell_row} < 11'(vwmcf_pkg::GRID_DIM));
      dx = $signed({2'b00, req_cell_col, 8'h00}) - 20'(robot_col_ff);
      dy = $signed({2'b00, req_cell_row, 8'h00}) - 20'(robot_row_ff);
      nx_in.org = (dx == 20'sd0) && (dy == 20'sd0);
      nx_in.ax  = (dx < 20'sd0) ? 19'(-dx) : 19'(dx);
      nx_in.ay  = (dy < 20'sd0) ? 19'(-dy) : 19'(dy);
      xe = 23'(dx);
      ye = 23'(dy);
      if (dx < 20'sd0) begin
         if (dy >= 20'sd0) begin
            nx_in.cx = ye;
            nx_in.cy = -xe;
            nx_in.cz = vwmcf_pkg::HALF_PI_Q16;
         end else begin
            nx_in.cx = -ye;
            nx_in.cy = xe;
            nx_in.cz = -vwmcf_pkg::HALF_PI_Q16;
         end
      end else begin
         nx_in.cx = xe;
         nx_in.cy = ye;
         nx_in.cz = 20'sd0;
      end
   end

   vwmcf_stage u_stg_in (
      .clock (clock), .reset (reset),
      .up_valid (req_valid), .up_lane (nx_in), .down_en (stg_en[ST_IN+1]),
      .stg_valid (stg_v[ST_IN]), .stg_lane (stg_d[ST_IN]), .up_en (stg_en[ST_IN])
   );

   // bearing rotation chain
   for (genvar gi = 0; gi < 16; gi++) begin : g_rot
      vwmcf_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (4'(gi)),
         .up_valid  (stg_v[ST_ROT0+gi-1]),
         .up_lane   (stg_d[ST_ROT0+gi-1]),
         .down_en   (stg_en[ST_ROT0+gi+1]),
         .stg_valid (stg_v[ST_ROT0+gi]),
         .stg_lane  (stg_d[ST_ROT0+gi]),
         .up_en     (stg_en[ST_ROT0+gi])
      );
   end

   // angle slot: bearing relative to heading, wrap, field of view test, squared offsets
   vwmcf_pkg::lane_type nx_ang;
   logic signed [20:0]  zr;
   logic signed [20:0]  bear;
   logic signed [18:0]  diff;
   logic signed [18:0]  md;

   always_comb begin
      nx_ang = stg_d[ST_ANG-1];
      zr     = 21'(stg_d[ST_ANG-1].cz) + 21'sd8;
      bear   = stg_d[ST_ANG-1].org ? 21'sd0 : (zr >>> 4);
      diff   = 19'(bear) - 19'(heading_ff);
      if (diff > vwmcf_pkg::PI_Q12) begin
         diff = diff - vwmcf_pkg::TWO_PI_Q12;
      end
      if (diff > vwmcf_pkg::PI_Q12) begin
         diff = diff - vwmcf_pkg::TWO_PI_Q12;
      end
      if (diff < -vwmcf_pkg::PI_Q12) begin
         diff = diff + vwmcf_pkg::TWO_PI_Q12;
      end
      if (diff < -vwmcf_pkg::PI_Q12) begin
         diff = diff + vwmcf_pkg::TWO_PI_Q12;
      end
      md = (diff < 19'sd0) ? -diff : diff;
      nx_ang.mag = md[13:0];
      nx_ang.fov = stg_d[ST_ANG-1].vis && (md[13:0] <= half_fov_ff);
      nx_ang.axx = 38'(stg_d[ST_ANG-1].ax) * 38'(stg_d[ST_ANG-1].ax);
      nx_ang.ayy = 38'(stg_d[ST_ANG-1].ay) * 38'(stg_d[ST_ANG-1].ay);
   end

   vwmcf_stage u_stg_ang (
      .clock (clock), .reset (reset),
      .up_valid (stg_v[ST_ANG-1]), .up_lane (nx_ang), .down_en (stg_en[ST_ANG+1]),
      .stg_valid (stg_v[ST_ANG]), .stg_lane (stg_d[ST_ANG]), .up_en (stg_en[ST_ANG])
   );

   // angle scaling and squared distance
   vwmcf_pkg::lane_type nx_mul1;

   always_comb begin
      nx_mul1    = stg_d[ST_MUL1-1];
      nx_mul1.t  = 30'(stg_d[ST_MUL1-1].mag) * 30'(angle_scale_ff);
      nx_mul1.sq = 39'(stg_d[ST_MUL1-1].axx) + 39'(stg_d[ST_MUL1-1].ayy);
   end

   vwmcf_stage u_stg_mul1 (
      .clock (clock), .reset (reset),
      .up_valid (stg_v[ST_MUL1-1]), .up_lane (nx_mul1), .down_en (stg_en[ST_MUL1+1]),
      .stg_valid (stg_v[ST_MUL1]), .stg_lane (stg_d[ST_MUL1]), .up_en (stg_en[ST_MUL1])
   );

   // squared angle term, distance term as two partial products
   vwmcf_pkg::lane_type nx_mul2;

   always_comb begin
      nx_mul2    = stg_d[ST_MUL2-1];
      nx_mul2.t2 = 60'(stg_d[ST_MUL2-1].t) * 60'(stg_d[ST_MUL2-1].t);
      nx_mul2.p0 = 44'(stg_d[ST_MUL2-1].sq[19:0]) * 44'(dist_scale_ff);
      nx_mul2.p1 = 43'(stg_d[ST_MUL2-1].sq[38:20]) * 43'(dist_scale_ff);
   end

   vwmcf_stage u_stg_mul2 (
      .clock (clock), .reset (reset),
      .up_valid (stg_v[ST_MUL2-1]), .up_lane (nx_mul2), .down_en (stg_en[ST_MUL2+1]),
      .stg_valid (stg_v[ST_MUL2]), .stg_lane (stg_d[ST_MUL2]), .up_en (stg_en[ST_MUL2])
   );

   // rounded exponents of both terms
   vwmcf_pkg::lane_type nx_sum;
   logic [60:0]         aa;
   logic [63:0]         ad;

   always_comb begin
      nx_sum        = stg_d[ST_SUM-1];
      aa            = 61'(stg_d[ST_SUM-1].t2) + 61'd16777216;
      ad            = 64'(stg_d[ST_SUM-1].p0) + (64'(stg_d[ST_SUM-1].p1) << 20)
                      + 64'd16777216;
      nx_sum.a_ang  = aa[60:25];
      nx_sum.a_dist = ad[63:25];
   end

   vwmcf_stage u_stg_sum (
      .clock (clock), .reset (reset),
      .up_valid (stg_v[ST_SUM-1]), .up_lane (nx_sum), .down_en (stg_en[ST_SUM+1]),
      .stg_valid (stg_v[ST_SUM]), .stg_lane (stg_d[ST_SUM]), .up_en (stg_en[ST_SUM])
   );

   // combined exponent, range checks, x = a/256 in Q.32
   vwmcf_pkg::lane_type nx_exp0;
   logic [39:0]         asum;

   always_comb begin
      nx_exp0      = stg_d[ST_EXP0-1];
      asum         = 40'(stg_d[ST_EXP0-1].a_ang) + 40'(stg_d[ST_EXP0-1].a_dist);
      nx_exp0.zero = (asum == 40'd0);
      nx_exp0.big  = (asum >= vwmcf_pkg::EXP_CUTOFF);
      nx_exp0.ex   = {asum[19:0], 8'h00};
   end

   vwmcf_stage u_stg_exp0 (
      .clock (clock), .reset (reset),
      .up_valid (stg_v[ST_EXP0-1]), .up_lane (nx_exp0), .down_en (stg_en[ST_EXP0+1]),
      .stg_valid (stg_v[ST_EXP0]), .stg_lane (stg_d[ST_EXP0]), .up_en (stg_en[ST_EXP0])
   );

   // x^2
   vwmcf_pkg::lane_type nx_exp2;
   logic [55:0]         m2;

   always_comb begin
      nx_exp2     = stg_d[ST_EXP2-1];
      m2          = 56'(stg_d[ST_EXP2-1].ex) * 56'(stg_d[ST_EXP2-1].ex);
      nx_exp2.ex2 = m2[55:32];
   end

   vwmcf_stage u_stg_exp2 (
      .clock (clock), .reset (reset),
      .up_valid (stg_v[ST_EXP2-1]), .up_lane (nx_exp2), .down_en (stg_en[ST_EXP2+1]),
      .stg_valid (stg_v[ST_EXP2]), .stg_lane (stg_d[ST_EXP2]), .up_en (stg_en[ST_EXP2])
   );

   // x^3
   vwmcf_pkg::lane_type nx_exp3;
   logic [51:0]         m3;

   always_comb begin
      nx_exp3     = stg_d[ST_EXP3-1];
      m3          = 52'(stg_d[ST_EXP3-1].ex2) * 52'(stg_d[ST_EXP3-1].ex);
      nx_exp3.ex3 = m3[51:32];
   end

   vwmcf_stage u_stg_exp3 (
      .clock (clock), .reset (reset),
      .up_valid (stg_v[ST_EXP3-1]), .up_lane (nx_exp3), .down_en (stg_en[ST_EXP3+1]),
      .stg_valid (stg_v[ST_EXP3]), .stg_lane (stg_d[ST_EXP3]), .up_en (stg_en[ST_EXP3])
   );

   // x^4 and x^3/6
   vwmcf_pkg::lane_type nx_exp4;
   logic [47:0]         m4;
   logic [40:0]         m6;

   always_comb begin
      nx_exp4     = stg_d[ST_EXP4-1];
      m4          = 48'(stg_d[ST_EXP4-1].ex3) * 48'(stg_d[ST_EXP4-1].ex);
      m6          = 41'(stg_d[ST_EXP4-1].ex3) * 41'(vwmcf_pkg::RECIP6);
      nx_exp4.ex4 = m4[47:32];
      nx_exp4.d6  = m6[39:23];
   end

   vwmcf_stage u_stg_exp4 (
      .clock (clock), .reset (reset),
      .up_valid (stg_v[ST_EXP4-1]), .up_lane (nx_exp4), .down_en (stg_en[ST_EXP4+1]),
      .stg_valid (stg_v[ST_EXP4]), .stg_lane (stg_d[ST_EXP4]), .up_en (stg_en[ST_EXP4])
   );

   // x^4/24 and the polynomial 1 - x + x^2/2 - x^3/6 + x^4/24
   vwmcf_pkg::lane_type nx_poly;
   logic [27:0]         m24;
   logic [33:0]         ps;

   always_comb begin
      nx_poly     = stg_d[ST_POLY-1];
      m24         = 28'(stg_d[ST_POLY-1].ex4[15:3]) * 28'(vwmcf_pkg::RECIP3);
      nx_poly.d24 = m24[27:16];
      ps          = 34'h1_0000_0000 - 34'(stg_d[ST_POLY-1].ex)
                    + 34'(stg_d[ST_POLY-1].ex2[23:1]) - 34'(stg_d[ST_POLY-1].d6)
                    + 34'(m24[27:16]);
      nx_poly.p   = ps[32:0];
   end

   vwmcf_stage u_stg_poly (
      .clock (clock), .reset (reset),
      .up_valid (stg_v[ST_POLY-1]), .up_lane (nx_poly), .down_en (stg_en[ST_POLY+1]),
      .stg_valid (stg_v[ST_POLY]), .stg_lane (stg_d[ST_POLY]), .up_en (stg_en[ST_POLY])
   );

   // squaring chain raises the polynomial to the 256th power
   for (genvar gs = 0; gs < 8; gs++) begin : g_sqr
      vwmcf_square_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .up_valid  (stg_v[ST_SQR0+gs-1]),
         .up_lane   (stg_d[ST_SQR0+gs-1]),
         .down_en   (stg_en[ST_SQR0+gs+1]),
         .stg_valid (stg_v[ST_SQR0+gs]),
         .stg_lane  (stg_d[ST_SQR0+gs]),
         .up_en     (stg_en[ST_SQR0+gs])
      );
   end

   // weight in Q1.16 with special cases
   vwmcf_pkg::lane_type nx_wgt;
   logic [33:0]         wr;

   always_comb begin
      nx_wgt = stg_d[ST_WGT-1];
      wr     = 34'(stg_d[ST_WGT-1].p) + 34'd32768;
      priority if (!stg_d[ST_WGT-1].fov) begin
         nx_wgt.w = '0;
      end else if (stg_d[ST_WGT-1].zero) begin
         nx_wgt.w = vwmcf_pkg::ONE_Q16;
      end else if (stg_d[ST_WGT-1].big) begin
         nx_wgt.w = '0;
      end else if (wr[33:16] > 18'(vwmcf_pkg::ONE_Q16)) begin
         nx_wgt.w = vwmcf_pkg::ONE_Q16;
      end else begin
         nx_wgt.w = wr[32:16];
      end
   end

   vwmcf_stage u_stg_wgt (
      .clock (clock), .reset (reset),
      .up_valid (stg_v[ST_WGT-1]), .up_lane (nx_wgt), .down_en (stg_en[ST_WGT+1]),
      .stg_valid (stg_v[ST_WGT]), .stg_lane (stg_d[ST_WGT]), .up_en (stg_en[ST_WGT])
   );

   // fusion: deposit into value, confidence takes the larger
   vwmcf_pkg::lane_type nx_out;
   logic [33:0]         cdm;
   logic [33:0]         dpm;
   logic [32:0]         vs;

   always_comb begin
      nx_out = stg_d[ST_OUT-1];
      cdm    = 34'(stg_d[ST_OUT-1].conf) * 34'(dec) + 34'd32768;
      dpm    = 34'(stg_d[ST_OUT-1].w) * 34'(dep) + 34'd32768;
      vs     = 33'(stg_d[ST_OUT-1].val) + 33'(dpm[32:16]);
      if (stg_d[ST_OUT-1].vis
          && ((stg_d[ST_OUT-1].conf != 17'd0) || (stg_d[ST_OUT-1].w != 17'd0))) begin
         nx_out.val  = vs[32] ? 32'hFFFF_FFFF : vs[31:0];
         nx_out.conf = (cdm[32:16] > stg_d[ST_OUT-1].w) ? cdm[32:16] : stg_d[ST_OUT-1].w;
      end
   end

   vwmcf_stage u_stg_out (
      .clock (clock), .reset (reset),
      .up_valid (stg_v[ST_OUT-1]), .up_lane (nx_out), .down_en (stg_en[ST_OUT+1]),
      .stg_valid (stg_v[ST_OUT]), .stg_lane (stg_d[ST_OUT]), .up_en (stg_en[ST_OUT])
   );

   // result word
   assign rsp_valid       = stg_v[ST_OUT];
   assign rsp_new_value   = stg_d[ST_OUT].val;
   assign rsp_new_conf    = stg_d[ST_OUT].conf;
   assign rsp_view_weight = stg_d[ST_OUT].w;

endmodule

`default_nettype wire

// ===== rtl/core/vwmcf_stage.sv =====
// ---------------------------------------------------------------------------
// vwmcf_stage
// One pipeline slot: holds a word and moves it on when the next slot frees.
// ---------------------------------------------------------------------------
`default_nettype none

module vwmcf_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               up_valid,
   input  wire vwmcf_pkg::lane_type up_lane,
   input  wire logic               down_en,
   output logic                    stg_valid,
   output vwmcf_pkg::lane_type     stg_lane,
   output logic                    up_en
);

   logic                valid_ff;
   vwmcf_pkg::lane_type lane_ff;

   // slot takes a word when empty or when its word moves on
   assign up_en = !valid_ff || down_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_en) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_en && up_valid) begin
         lane_ff <= up_lane;
      end
   end

   assign stg_valid = valid_ff;
   assign stg_lane  = lane_ff;

endmodule

`default_nettype wire

// ===== rtl/core/vwmcf_cordic_cell.sv =====
// ---------------------------------------------------------------------------
// vwmcf_cordic_cell
// One vectoring rotation of the bearing chain, registered.
// ---------------------------------------------------------------------------
`default_nettype none

module vwmcf_cordic_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [3:0]         shift,
   input  wire logic               up_valid,
   input  wire vwmcf_pkg::lane_type up_lane,
   input  wire logic               down_en,
   output logic                    stg_valid,
   output vwmcf_pkg::lane_type     stg_lane,
   output logic                    up_en
);

   logic signed [22:0]  xs;
   logic signed [22:0]  ys;
   logic signed [19:0]  ang;
   vwmcf_pkg::lane_type nx;

   // rotate toward the x axis, accumulate the angle
   always_comb begin
      nx  = up_lane;
      xs  = up_lane.cx >>> shift;
      ys  = up_lane.cy >>> shift;
      ang = $signed(vwmcf_pkg::ATAN_TAB[shift]);
      if (up_lane.cy > 23'sd0) begin
         nx.cx = up_lane.cx + ys;
         nx.cy = up_lane.cy - xs;
         nx.cz = up_lane.cz + ang;
      end else begin
         nx.cx = up_lane.cx - ys;
         nx.cy = up_lane.cy + xs;
         nx.cz = up_lane.cz - ang;
      end
   end

   vwmcf_stage u_stage (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (up_valid),
      .up_lane   (nx),
      .down_en   (down_en),
      .stg_valid (stg_valid),
      .stg_lane  (stg_lane),
      .up_en     (up_en)
   );

endmodule

`default_nettype wire

// ===== rtl/core/vwmcf_square_cell.sv =====
// ---------------------------------------------------------------------------
// vwmcf_square_cell
// One rounded squaring of the exponential polynomial, registered.
// ---------------------------------------------------------------------------
`default_nettype none

module vwmcf_square_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               up_valid,
   input  wire vwmcf_pkg::lane_type up_lane,
   input  wire logic               down_en,
   output logic                    stg_valid,
   output vwmcf_pkg::lane_type     stg_lane,
   output logic                    up_en
);

   logic [65:0]         prod;
   logic [65:0]         rnd;
   vwmcf_pkg::lane_type nx;

   // p = round(p * p) in Q.32
   always_comb begin
      nx   = up_lane;
      prod = 66'(up_lane.p) * 66'(up_lane.p);
      rnd  = prod + 66'd2147483648;
      nx.p = rnd[64:32];
   end

   vwmcf_stage u_stage (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (up_valid),
      .up_lane   (nx),
      .down_en   (down_en),
      .stg_valid (stg_valid),
      .stg_lane  (stg_lane),
      .up_en     (up_en)
   );

endmodule

`default_nettype wire

// ===== test/tb_view_weighted_map_cell_fusion.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_view_weighted_map_cell_fusion
// Self-checking bench for the view weighted map cell fusion pipeline.
// ---------------------------------------------------------------------------
// Cell words are sent through the req channel while, in most random phases, the
// rsp channel stalls in random bursts. Every accepted word is run through a local
// fixed point model of the fusion step, and each result word is compared with the
// oldest one. Directed cells and register extremes come first, then random settings
// with random cells placed mostly around the robot so the view weight is exercised.

module tb_view_weighted_map_cell_fusion;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 60;

   typedef struct packed {
      logic [31:0] value;
      logic [16:0] conf;
      logic [16:0] weight;
   } fused_cell_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [9:0]  req_cell_col = '0;
   logic [9:0]  req_cell_row = '0;
   logic        req_in_view = 1'b0;
   logic        req_apply_decay = 1'b0;
   logic [31:0] req_prev_value = '0;
   logic [16:0] req_prev_conf = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_new_value;
   logic [16:0] rsp_new_conf;
   logic [16:0] rsp_view_weight;

   view_weighted_map_cell_fusion dut (.*);

   always #5 clock = ~clock;

   // shadow copy of the registers, masked to their widths
   logic [23:0] shadow_reg [8] = '{24'd0, 24'd0, 24'd0, 24'(vwmcf_pkg::RST_HALF_FOV),
      24'(vwmcf_pkg::RST_ANGLE_SCALE), 24'(vwmcf_pkg::RST_DIST_SCALE),
      24'(vwmcf_pkg::RST_DEPOSIT_SCALE), 24'(vwmcf_pkg::RST_DECAY)};
   localparam int REG_BITS [8] = '{19, 19, 16, 14, 16, 24, 17, 17};

   fused_cell_type fused_q [$];
   fused_cell_type want;
   int errors = 0, cells_sent = 0, words_checked = 0, settings_done = 0;
   int req_idle_pct = 0, rsp_idle_pct = 0;
   int rsp_burst = 0, quiet_cycles = 0;

   // ------------------------------------------------------------------
   // fixed point model
   // ------------------------------------------------------------------
   function automatic longint signed sext_reg(logic [23:0] v, int w);
      longint signed r;
      r = longint'(v) & ((64'sd1 <<< w) - 1);
      if (r[w-1])
         r = r - (64'sd1 <<< w);
      return r;
   endfunction

   function automatic longint unsigned round_q16(longint unsigned v, longint unsigned f);
      return (v * f + 64'd32768) >> 16;
   endfunction

   // cordic bearing of (x, y), Q.16 internally, Q4.12 out
   function automatic longint signed bearing_q12(longint signed x, longint signed y);
      longint signed z, t, xs, ys;
      z = 0;
      if (x == 0 && y == 0)
         return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = 102944;
         end else begin
            x = -y; y = t; z = -102944;
         end
      end
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; z += longint'(vwmcf_pkg::ATAN_TAB[i]);
         end else begin
            x -= ys; y += xs; z -= longint'(vwmcf_pkg::ATAN_TAB[i]);
         end
      end
      return (z + 8) >>> 4;
   endfunction

   // exp(-a) in Q1.16 by a short series raised to the 256th power
   function automatic longint unsigned neg_exp_q16(longint unsigned a);
      logic [127:0] p;
      longint unsigned x, x2, x3, x4, w;
      if (a == 0)
         return 65536;
      if (a >= (64'd12 << 16))
         return 0;
      x = a << 8;
      x2 = (x * x) >> 32;
      x3 = (x2 * x) >> 32;
      x4 = (x3 * x) >> 32;
      p = (128'd1 << 32) - x + (x2 >> 1) - x3 / 6 + x4 / 24;
      for (int i = 0; i < 8; i++)
         p = (p * p + (128'd1 << 31)) >> 32;
      w = 64'((p + 128'd32768) >> 16);
      return w > 65536 ? 65536 : w;
   endfunction

   function automatic fused_cell_type fuse_cell(logic [9:0] col, logic [9:0] row, logic vis,
                                                logic mv, logic [31:0] pv, logic [16:0] pc);
      fused_cell_type r;
      longint unsigned val, conf, dec, dep, w, mag, t, ax, ay, a_ang, a_dist, cd;
      longint signed dx, dy, diff;
      val = pv;
      conf = pc > 65536 ? 65536 : pc;
      dec = shadow_reg[vwmcf_pkg::REG_DECAY] > 65536 ? 65536
            : shadow_reg[vwmcf_pkg::REG_DECAY];
      dep = shadow_reg[vwmcf_pkg::REG_DEPOSIT_SCALE] > 65536 ? 65536
            : shadow_reg[vwmcf_pkg::REG_DEPOSIT_SCALE];
      w = 0;
      if (mv) begin
         val = round_q16(val, dec);
         conf = round_q16(conf, dec);
      end
      if (vis) begin
         dx = longint'(col) * 256 - sext_reg(shadow_reg[vwmcf_pkg::REG_ROBOT_COL], 19);
         dy = longint'(row) * 256 - sext_reg(shadow_reg[vwmcf_pkg::REG_ROBOT_ROW], 19);
         diff = bearing_q12(dx, dy) - sext_reg(shadow_reg[vwmcf_pkg::REG_HEADING], 16);
         while (diff > 12868)
            diff -= 25736;
         while (diff < -12868)
            diff += 25736;
         mag = diff < 0 ? -diff : diff;
         if (mag <= shadow_reg[vwmcf_pkg::REG_HALF_FOV]) begin
            t = mag * shadow_reg[vwmcf_pkg::REG_ANGLE_SCALE];
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            a_ang = (t * t + (64'd1 << 24)) >> 25;
            a_dist = ((ax * ax + ay * ay) * shadow_reg[vwmcf_pkg::REG_DIST_SCALE]
                      + (64'd1 << 24)) >> 25;
            w = neg_exp_q16(a_ang + a_dist);
         end
         // skipped when neither confidence nor weight is present
         if (conf + w != 0) begin
            cd = round_q16(conf, dec);
            val += round_q16(w, dep);
            if (val > 64'hFFFF_FFFF)
               val = 64'hFFFF_FFFF;
            conf = cd > w ? cd : w;
         end
      end
      r.value = val[31:0];
      r.conf = conf[16:0];
      r.weight = w[16:0];
      return r;
   endfunction

   // ------------------------------------------------------------------
   // driving tasks
   // ------------------------------------------------------------------
   task automatic send_cell(logic [9:0] col, logic [9:0] row, logic vis, logic mv,
                            logic [31:0] pv, logic [16:0] pc);
      if (req_idle_pct > 0 && $urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cell_col <= col;
      req_cell_row <= row;
      req_in_view <= vis;
      req_apply_decay <= mv;
      req_prev_value <= pv;
      req_prev_conf <= pc;
      do @(posedge clock); while (req_stall);
      fused_q = {fused_q, fuse_cell(col, row, vis, mv, pv, pc)};
      cells_sent++;
   endtask

   // lower valid and wait until every result word is back
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (fused_q.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write all eight registers, block idle
   task automatic set_regs(logic [23:0] v [8]);
      for (int i = 0; i < 8; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= v[i];
         shadow_reg[i] = v[i] & ((24'd1 << REG_BITS[i]) - 24'd1);
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
      settings_done++;
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_directed_cells;
      // robot on the cell, with and without confidence
      send_cell(10'd0, 10'd0, 1'b1, 1'b0, 32'd0, 17'd0);
      send_cell(10'd0, 10'd0, 1'b1, 1'b1, 32'd1000, 17'd30000);
      // value overflow and confidence above one
      send_cell(10'd0, 10'd0, 1'b1, 1'b0, 32'hFFFF_FFFF, 17'h1FFFF);
      send_cell(10'd0, 10'd0, 1'b1, 1'b1, 32'hFFFF_FFF0, 17'd65536);
      // far corner, outside the default field of view
      send_cell(10'd1023, 10'd1023, 1'b1, 1'b0, 32'h1234_5678, 17'd40000);
      // out of view with no confidence: only the decay applies
      send_cell(10'd1023, 10'd1023, 1'b1, 1'b1, 32'h0000_FFFF, 17'd0);
      // straight ahead and near
      send_cell(10'd3, 10'd0, 1'b1, 1'b0, 32'd65536, 17'd100);
      send_cell(10'd20, 10'd2, 1'b1, 1'b1, 32'h8000_0000, 17'd65535);
      // not in view: no fusion, with and without decay
      send_cell(10'd5, 10'd0, 1'b0, 1'b1, 32'hDEAD_BEEF, 17'h1FFFF);
      send_cell(10'd5, 10'd0, 1'b0, 1'b0, 32'hDEAD_BEEF, 17'd12345);
      drain();
   endtask

   task automatic test_register_extremes;
      logic [23:0] v [8];
      // robot at the far corner, largest heading, wide open view, gains above one
      v = '{24'h3FFFF, 24'h3FFFF, 24'h7FFF, 24'h3FFF, 24'd0, 24'd0, 24'h1FFFF, 24'h1FFFF};
      set_regs(v);
      send_cell(10'd0, 10'd0, 1'b1, 1'b1, 32'hFFFF_0000, 17'd50000);
      send_cell(10'd1023, 10'd0, 1'b1, 1'b0, 32'd7, 17'd0);
      send_cell(10'd1023, 10'd1023, 1'b1, 1'b1, 32'hFFFF_FFFF, 17'd1);
      drain();
      // most negative position and heading, sharpest weights, zero gains
      v = '{24'h40000, 24'h40000, 24'h8000, 24'd0, 24'hFFFF, 24'hFFFFFF, 24'd0, 24'd0};
      set_regs(v);
      send_cell(10'd0, 10'd0, 1'b1, 1'b1, 32'hFFFF_FFFF, 17'h1FFFF);
      send_cell(10'd512, 10'd512, 1'b1, 1'b0, 32'd99, 17'd65536);
      drain();
      // exact unit gains, robot on cell
      v = '{24'h00A00, 24'h00A00, 24'd0, 24'd12868, 24'd256, 24'd1, 24'd65536, 24'd65536};
      set_regs(v);
      send_cell(10'd10, 10'd10, 1'b1, 1'b1, 32'hFFFF_8000, 17'd0);
      send_cell(10'd12, 10'd10, 1'b1, 1'b0, 32'd0, 17'd0);
      send_cell(10'd8, 10'd10, 1'b1, 1'b0, 32'd0, 17'd0);
      drain();
   endtask

   task automatic random_cell;
      longint signed rc, rr;
      int c, r;
      logic [31:0] pv;
      logic [16:0] pc;
      rc = sext_reg(shadow_reg[vwmcf_pkg::REG_ROBOT_COL], 19) >>> 8;
      rr = sext_reg(shadow_reg[vwmcf_pkg::REG_ROBOT_ROW], 19) >>> 8;
      if ($urandom_range(0, 3) != 0) begin
         c = int'(rc) + $urandom_range(0, 48) - 24;
         r = int'(rr) + $urandom_range(0, 48) - 24;
         c = c < 0 ? 0 : (c > 1023 ? 1023 : c);
         r = r < 0 ? 0 : (r > 1023 ? 1023 : r);
      end else begin
         c = $urandom_range(0, 1023);
         r = $urandom_range(0, 1023);
      end
      pv = $urandom();
      if ($urandom_range(0, 7) == 0)
         pv = 32'hFFFF_FFFF - $urandom_range(0, 70000);
      case ($urandom_range(0, 5))
         0: pc = 17'd0;
         1: pc = 17'd65536;
         default: pc = 17'($urandom_range(0, 131071));
      endcase
      send_cell(10'(c), 10'(r), $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)), pv, pc);
   endtask

   task automatic test_random_settings(int phase_count, int cells_per_phase);
      logic [23:0] v [8];
      for (int ph = 0; ph < phase_count; ph++) begin
         v[vwmcf_pkg::REG_ROBOT_COL] = ($urandom_range(0, 7) == 0) ? 24'($urandom())
                                       : 24'($urandom_range(0, 1023 * 256));
         v[vwmcf_pkg::REG_ROBOT_ROW] = ($urandom_range(0, 7) == 0) ? 24'($urandom())
                                       : 24'($urandom_range(0, 1023 * 256));
         v[vwmcf_pkg::REG_HEADING] = 24'($urandom_range(0, 65535));
         v[vwmcf_pkg::REG_HALF_FOV] = 24'($urandom_range(0, 16383));
         v[vwmcf_pkg::REG_ANGLE_SCALE] = ($urandom_range(0, 3) == 0)
                                         ? 24'($urandom_range(0, 65535))
                                         : 24'($urandom_range(0, 2000));
         v[vwmcf_pkg::REG_DIST_SCALE] = ($urandom_range(0, 3) == 0) ? 24'($urandom())
                                        : 24'($urandom_range(0, 30000));
         v[vwmcf_pkg::REG_DEPOSIT_SCALE] = 24'($urandom_range(0, 131071));
         v[vwmcf_pkg::REG_DECAY] = ($urandom_range(0, 1) == 0)
                                   ? 24'($urandom_range(0, 131071))
                                   : 24'($urandom_range(60000, 65536));
         set_regs(v);
         // idling ends in the last phase, and some phases run without it
         if (ph == phase_count - 1 || $urandom_range(0, 4) == 0) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = $urandom_range(5, 40);
            rsp_idle_pct = $urandom_range(2, 15);
         end
         repeat (cells_per_phase) random_cell();
         drain();
      end
   endtask

   // ------------------------------------------------------------------
   // result side stall bursts
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_burst > 1) begin
         rsp_burst <= rsp_burst - 1;
      end else if (rsp_burst == 1 || rsp_idle_pct == 0) begin
         rsp_burst <= 0;
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < rsp_idle_pct) begin
         rsp_stall <= 1'b1;
         rsp_burst <= $urandom_range(1, 19);
      end
   end

   // compare each result word with the oldest expected one
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (fused_q.size() == 0) begin
            $error("result word with none expected");
            errors++;
         end else begin
            want = fused_q.pop_front();
            words_checked++;
            if (rsp_new_value !== want.value) begin
               $error("new_value expected %h actual %h", want.value, rsp_new_value);
               errors++;
            end
            if (rsp_new_conf !== want.conf) begin
               $error("new_conf expected %0d actual %0d", want.conf, rsp_new_conf);
               errors++;
            end
            if (rsp_view_weight !== want.weight) begin
               $error("view_weight expected %0d actual %0d", want.weight, rsp_view_weight);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without progress while work is pending
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else if (req_valid || fused_q.size() > 0)
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout with %0d result words outstanding", fused_q.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cells();
      test_register_extremes();
      test_random_settings(6, 122);
      if (fused_q.size() > 0) begin
         $error("%0d expected result words never arrived", fused_q.size());
         errors++;
      end
      $display("sent %0d cell words over %0d register settings, checked %0d result words",
               cells_sent, settings_done, words_checked);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
